/* design/atu_pkg.sv */
// shared types and constants for the affine transform unit
// no dependencies; imported by affine_transform_unit_core
`timescale 1ns / 1ps

package atu_pkg;

  localparam int WORD_W  = 32;
  localparam int MAT_N   = 12;
  localparam int ROWS    = 3;
  localparam int COLS    = 4;
  localparam int IDX_W   = 4;
  localparam int ACT_W   = 3;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int SUM_W   = PROD_W + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 3'd0,
    ACT_POINT  = 3'd1,
    ACT_DIR    = 3'd2,
    ACT_VEC4   = 3'd3,
    ACT_INVERT = 3'd4
  } action_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] value;
  } sat_t;

endpackage

/* design/affine_transform_unit_core.sv */
// affine transform unit core: 3x4 matrix store, transform and rigid invert datapath
// depends on atu_pkg
`timescale 1ns / 1ps

// Takes one word per cycle on the input channel while in_stall is low. Loads (action 0) pass
// through the input register, then update the matrix and give no result. Point, direction
// and vec4 transforms run through twelve parallel 32x32 multipliers into a product register,
// then a sum-and-saturate stage into the result register; a new word can follow every cycle
// unless the output stalls. A rigid invert reuses nine of the same multipliers, writes the
// matrix from the product register, and holds the input stalled while it sits in the input
// register, leaving a bubble. Actions 5 to 7 are accepted and dropped. Saturation clamps to
// min(DATA_WIDTH, 32) bits; results are sign-extended to 32 bits. The matrix resets to identity.
module affine_transform_unit_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [atu_pkg::ACT_W-1:0]         action,
  input  logic [atu_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [atu_pkg::WORD_W-1:0] coef_value,
  input  logic signed [atu_pkg::WORD_W-1:0] in_x,
  input  logic signed [atu_pkg::WORD_W-1:0] in_y,
  input  logic signed [atu_pkg::WORD_W-1:0] in_z,
  input  logic signed [atu_pkg::WORD_W-1:0] in_w,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [atu_pkg::WORD_W-1:0] out_x,
  output logic signed [atu_pkg::WORD_W-1:0] out_y,
  output logic signed [atu_pkg::WORD_W-1:0] out_z,
  output logic signed [atu_pkg::WORD_W-1:0] out_w,
  output logic                              saturated
);

  import atu_pkg::*;

  localparam int SAT_W = (DATA_WIDTH > WORD_W) ? WORD_W : DATA_WIDTH;
  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [WORD_W-1:0] SAT_HI_W = SAT_HI[WORD_W-1:0];
  localparam logic [WORD_W-1:0] SAT_LO_W = SAT_LO[WORD_W-1:0];
  localparam logic [WORD_W-1:0] ONE_Q = {{(WORD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  function automatic sat_t sat_clamp(input logic signed [SUM_W-1:0] v);
    sat_t s;
    s.hit   = 1'b0;
    s.value = v[WORD_W-1:0];
    if (v > SAT_HI) begin
      s.hit   = 1'b1;
      s.value = SAT_HI_W;
    end else if (v < SAT_LO) begin
      s.hit   = 1'b1;
      s.value = SAT_LO_W;
    end
    return s;
  endfunction

  // matrix store
  logic signed [WORD_W-1:0] matrix      [MAT_N];
  logic signed [WORD_W-1:0] matrix_next [MAT_N];

  // input register
  logic                     s1_valid;
  logic [ACT_W-1:0]         s1_action;
  logic [IDX_W-1:0]         s1_index;
  logic signed [WORD_W-1:0] s1_value;
  logic signed [WORD_W-1:0] s1_vec [COLS];

  // product register
  logic                     s2_valid;
  logic                     s2_inv;
  logic [ACT_W-1:0]         s2_action;
  logic signed [WORD_W-1:0] s2_w;
  logic signed [PROD_W-1:0] s2_prod [MAT_N];

  logic signed [WORD_W-1:0] op_a     [MAT_N];
  logic signed [WORD_W-1:0] op_b     [MAT_N];
  logic signed [PROD_W-1:0] prod_raw [MAT_N];
  logic signed [PROD_W-1:0] prod_sh  [MAT_N];

  logic s1_is_inv, s1_is_xform, s1_is_load;
  logic s2_go, s2_free, s1_go, s1_free, out_ready, in_accept;

  logic signed [SUM_W-1:0] acc [ROWS];
  sat_t                    sat [ROWS];

  always_comb begin
    s1_is_inv   = 1'b0;
    s1_is_xform = 1'b0;
    s1_is_load  = 1'b0;
    case (s1_action)
      ACT_LOAD:   s1_is_load  = 1'b1;
      ACT_POINT:  s1_is_xform = 1'b1;
      ACT_DIR:    s1_is_xform = 1'b1;
      ACT_VEC4:   s1_is_xform = 1'b1;
      ACT_INVERT: s1_is_inv   = 1'b1;
      default: begin
      end
    endcase
  end

  // pipeline control
  assign out_ready = !out_valid || !out_stall;
  assign s2_go     = s2_valid && (s2_inv || out_ready);
  assign s2_free   = !s2_valid || s2_go;
  assign s1_go     = s1_valid && (!(s1_is_xform || s1_is_inv) || s2_free);
  assign s1_free   = !s1_valid || s1_go;
  assign in_stall  = !s1_free || (s1_valid && s1_is_inv);
  assign in_accept = in_valid && !in_stall;

  // multiplier operand select
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (s1_is_inv) begin
          if (c < ROWS) begin
            op_a[r*COLS+c] = matrix[c*COLS+r];
            op_b[r*COLS+c] = matrix[c*COLS+COLS-1];
          end else begin
            op_a[r*COLS+c] = '0;
            op_b[r*COLS+c] = '0;
          end
        end else begin
          op_a[r*COLS+c] = matrix[r*COLS+c];
          op_b[r*COLS+c] = s1_vec[c];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      prod_raw[i] = op_a[i] * op_b[i];
      prod_sh[i]  = prod_raw[i] >>> FRAC_BITS;
    end
    // translation column: added as is for a point, dropped for a direction
    for (int r = 0; r < ROWS; r++) begin
      if (s1_action == ACT_POINT) begin
        prod_sh[r*COLS+COLS-1] = {{WORD_W{matrix[r*COLS+COLS-1][WORD_W-1]}},
                                  matrix[r*COLS+COLS-1]};
      end else if (s1_action == ACT_DIR) begin
        prod_sh[r*COLS+COLS-1] = '0;
      end
    end
  end

  // row sums (negated for an invert) and clamp
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      acc[r] = SUM_W'(s2_prod[r*COLS]) + SUM_W'(s2_prod[r*COLS+1])
             + SUM_W'(s2_prod[r*COLS+2]) + SUM_W'(s2_prod[r*COLS+3]);
      if (s2_inv) begin
        acc[r] = -acc[r];
      end
      sat[r] = sat_clamp(acc[r]);
    end
  end

  always_comb begin
    for (int i = 0; i < MAT_N; i++) begin
      matrix_next[i] = matrix[i];
    end
    if (s1_go && s1_is_load && (s1_index < IDX_W'(MAT_N))) begin
      matrix_next[s1_index] = s1_value;
    end else if (s2_valid && s2_inv) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < ROWS; c++) begin
          matrix_next[r*COLS+c] = matrix[c*COLS+r];
        end
        matrix_next[r*COLS+COLS-1] = sat[r].value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAT_N; i++) begin
        matrix[i] <= ((i % (COLS + 1)) == 0) ? ONE_Q : '0;
      end
    end else begin
      for (int i = 0; i < MAT_N; i++) begin
        matrix[i] <= matrix_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_accept;
      end
      if (s2_free) begin
        s2_valid <= s1_go && (s1_is_xform || s1_is_inv);
      end
      if (out_ready) begin
        out_valid <= s2_go && !s2_inv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action <= action;
      s1_index  <= coef_index;
      s1_value  <= coef_value;
      s1_vec[0] <= in_x;
      s1_vec[1] <= in_y;
      s1_vec[2] <= in_z;
      s1_vec[3] <= in_w;
    end
    if (s1_go && s2_free) begin
      s2_inv    <= s1_is_inv;
      s2_action <= s1_action;
      s2_w      <= s1_vec[COLS-1];
      for (int i = 0; i < MAT_N; i++) begin
        s2_prod[i] <= prod_sh[i];
      end
    end
    if (s2_go && !s2_inv && out_ready) begin
      out_x     <= sat[0].value;
      out_y     <= sat[1].value;
      out_z     <= sat[2].value;
      saturated <= sat[0].hit || sat[1].hit || sat[2].hit;
      if (s2_action == ACT_POINT) begin
        out_w <= ONE_Q;
      end else if (s2_action == ACT_DIR) begin
        out_w <= '0;
      end else begin
        out_w <= s2_w;
      end
    end
  end

  // invert leaves a bubble behind it
  a_inv_bubble: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_inv |-> !s1_valid)
    else $error("word behind invert entered before matrix update");

  a_inv_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_is_inv |-> in_stall)
    else $error("input taken while invert pending");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_inv && out_valid && out_stall |=> s2_valid && $stable(s2_prod[0]))
    else $error("product stage lost a word under output stall");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == SAT_HI_W) || (out_x == SAT_LO_W) ||
      (out_y == SAT_HI_W) || (out_y == SAT_LO_W) ||
      (out_z == SAT_HI_W) || (out_z == SAT_LO_W))
    else $error("clamp flag without a clamped component");

endmodule
